>>> hdl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants and types for the byte deque engine
// ----------------------------------------------------------------------------
package deq_pkg;
  localparam int DepthDef = 128;
  localparam logic [7:0] CapReset = 8'd100;

  localparam logic [3:0] OpPushFront = 4'd0;
  localparam logic [3:0] OpPushRear  = 4'd1;
  localparam logic [3:0] OpPopFront  = 4'd2;
  localparam logic [3:0] OpPopRear   = 4'd3;
  localparam logic [3:0] OpPeekFront = 4'd4;
  localparam logic [3:0] OpPeekRear  = 4'd5;
  localparam logic [3:0] OpReplFront = 4'd6;
  localparam logic [3:0] OpReplRear  = 4'd7;
  localparam logic [3:0] OpRotRtoF   = 4'd8;
  localparam logic [3:0] OpRotFtoR   = 4'd9;
  localparam logic [3:0] OpFind      = 4'd10;
  localparam logic [3:0] OpCount     = 4'd11;
  localparam logic [3:0] OpDedup     = 4'd12;
  localparam logic [3:0] OpClear     = 4'd13;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SEEN_CLR, S_SCAN, S_DONE
  } state_t;
endpackage

>>> hdl/double_ended_queue_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_engine
// byte deque in a ring memory with find, count and dedup scans
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready (op, value) and one result item leaves on
// out_valid/out_ready for each. The user must assert cfg_we, which writes
// the capacity register, only while the block is idle; the block does not
// enforce it. State sits in a one-port-read ring memory with a registered
// read; pushes, replace and clear update state on accept and go straight to
// S_DONE, while pop, peek and rotate first read an end entry in S_RD. Find
// and count walk the stored bytes one per cycle; dedup first clears its
// 256-entry seen memory, then walks the bytes. The result sits in an output
// register: the next item is taken only after it is delivered, so a stalled
// receiver holds the block. Reset clears pointers, fill count and capacity
// (to 100); the ring memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_engine #(
  parameter int DEPTH = deq_pkg::DepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_op,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_result_byte,
  output logic [7:0] out_position,
  output logic [7:0] out_matches_res,
  output logic [7:0] out_fill_count,
  output logic       out_empty_flag,
  output logic       out_full_flag,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0] mem [DEPTH];
  logic       seen [256];

  state_t     state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0] cap_r;
  logic [3:0] op_r, op_nxt;
  logic [7:0] val_r, val_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [7:0] hit_r, hit_nxt;
  logic       found_r, found_nxt;
  logic       rv_r, rv_nxt;
  logic       dv_r, dv_nxt;
  logic [7:0] db_r, db_nxt;
  logic       lw_r, lw_nxt;
  logic [7:0] lb_r, lb_nxt;
  logic [7:0] rd_q;
  logic       sn_q;

  logic          m_we;
  logic [AW-1:0] m_wa, m_ra;
  logic [7:0]    m_wd;
  logic          s_we, s_wd;
  logic [7:0]    s_wa, s_ra;

  logic       ov_r, ov_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic [7:0] orb_r, orb_nxt, opos_r, opos_nxt, omat_r, omat_nxt;

  logic [CW-1:0] effcap;
  logic          full_now;
  logic [AW-1:0] rear_a, tail_a, hm1;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign effcap = (int'(cap_r) > DEPTH) ? CW'(DEPTH) : CW'(cap_r);
  assign full_now = cnt_r >= effcap;
  assign rear_a = slot(head_r, cnt_r - CW'(1));
  assign tail_a = slot(head_r, cnt_r);
  assign hm1 = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign in_ready = (state_r == S_IDLE) && !ov_r;

  always_ff @(posedge clk) begin
    if (m_we) mem[m_wa] <= m_wd;
    rd_q <= mem[m_ra];
    if (s_we) seen[s_wa] <= s_wd;
    sn_q <= seen[s_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      cnt_r <= '0;
      cap_r <= CapReset;
      ov_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      rv_r <= rv_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
    op_r <= op_nxt;
    val_r <= val_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    hit_r <= hit_nxt;
    found_r <= found_nxt;
    dv_r <= dv_nxt;
    db_r <= db_nxt;
    lw_r <= lw_nxt;
    lb_r <= lb_nxt;
    ost_r <= ost_nxt;
    orb_r <= orb_nxt;
    opos_r <= opos_nxt;
    omat_r <= omat_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    cnt_nxt = cnt_r;
    op_nxt = op_r;
    val_nxt = val_r;
    i_nxt = i_r;
    j_nxt = j_r;
    hit_nxt = hit_r;
    found_nxt = found_r;
    rv_nxt = 1'b0;
    dv_nxt = 1'b0;
    db_nxt = db_r;
    lw_nxt = 1'b0;
    lb_nxt = lb_r;
    ov_nxt = ov_r && !out_ready;
    ost_nxt = ost_r;
    orb_nxt = orb_r;
    opos_nxt = opos_r;
    omat_nxt = omat_r;
    m_we = 1'b0;
    m_wa = head_r;
    m_wd = val_r;
    m_ra = head_r;
    s_we = 1'b0;
    s_wd = 1'b0;
    s_wa = hit_r;
    s_ra = rd_q;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_op;
          val_nxt = in_value;
          ost_nxt = StOk;
          orb_nxt = '0;
          opos_nxt = '0;
          omat_nxt = '0;
          i_nxt = '0;
          j_nxt = '0;
          hit_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_op)
            OpPushFront, OpPushRear: begin
              if (full_now) ost_nxt = StFull;
              else begin
                m_we = 1'b1;
                m_wd = in_value;
                m_wa = (in_op == OpPushFront) ? hm1 : tail_a;
                if (in_op == OpPushFront) head_nxt = hm1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OpPopFront, OpPopRear, OpPeekFront, OpPeekRear,
            OpReplFront, OpReplRear: begin
              if (cnt_r == '0) ost_nxt = StEmpty;
              else if (in_op == OpReplFront || in_op == OpReplRear) begin
                m_we = 1'b1;
                m_wd = in_value;
                m_wa = in_op[0] ? rear_a : head_r;
              end else begin
                m_ra = in_op[0] ? rear_a : head_r;
                state_nxt = S_RD;
              end
            end
            OpRotRtoF, OpRotFtoR: begin
              if (cnt_r >= CW'(2)) begin
                m_ra = (in_op == OpRotRtoF) ? rear_a : head_r;
                state_nxt = S_RD;
              end
            end
            OpFind, OpCount: begin
              m_ra = head_r;
              rv_nxt = cnt_r != '0;
              i_nxt = CW'(1);
              state_nxt = S_SCAN;
            end
            OpDedup: begin
              state_nxt = S_SEEN_CLR;
            end
            OpClear: begin
              cnt_nxt = '0;
              head_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_DONE;
        case (op_r)
          OpPopFront: begin
            orb_nxt = rd_q;
            head_nxt = slot(head_r, CW'(1));
            cnt_nxt = cnt_r - CW'(1);
          end
          OpPopRear: begin
            orb_nxt = rd_q;
            cnt_nxt = cnt_r - CW'(1);
          end
          OpPeekFront, OpPeekRear: orb_nxt = rd_q;
          OpRotRtoF: begin
            m_we = 1'b1;
            m_wa = hm1;
            m_wd = rd_q;
            head_nxt = hm1;
          end
          OpRotFtoR: begin
            m_we = 1'b1;
            m_wa = tail_a;
            m_wd = rd_q;
            head_nxt = slot(head_r, CW'(1));
          end
          default: ;
        endcase
      end
      S_SEEN_CLR: begin
        s_we = 1'b1;
        s_wa = hit_r;
        hit_nxt = hit_r + 8'd1;
        if (hit_r == 8'd255) begin
          m_ra = head_r;
          rv_nxt = cnt_r != '0;
          i_nxt = CW'(1);
          j_nxt = '0;
          hit_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        m_ra = slot(head_r, i_r);
        if (i_r < cnt_r) begin
          rv_nxt = 1'b1;
          i_nxt = i_r + CW'(1);
        end
        if (rv_r) begin
          case (op_r)
            OpFind: begin
              if (!found_r && rd_q == val_r) begin
                found_nxt = 1'b1;
                opos_nxt = 8'(i_r);
              end
            end
            OpCount: begin
              if (rd_q == val_r) hit_nxt = hit_r + 8'd1;
            end
            default: begin
              s_ra = rd_q;
              dv_nxt = 1'b1;
              db_nxt = rd_q;
            end
          endcase
        end
        // dedup second stage, forward the seen bit written last cycle
        if (dv_r) begin
          if (!(sn_q || (lw_r && lb_r == db_r))) begin
            s_we = 1'b1;
            s_wa = db_r;
            s_wd = 1'b1;
            m_we = 1'b1;
            m_wa = slot(head_r, j_r);
            m_wd = db_r;
            j_nxt = j_r + CW'(1);
            lw_nxt = 1'b1;
            lb_nxt = db_r;
          end
        end
        if (!rv_nxt && !dv_nxt) begin
          omat_nxt = (op_r == OpCount) ? hit_nxt : 8'd0;
          if (op_r == OpDedup) cnt_nxt = j_nxt;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_result_byte = orb_r;
  assign out_position = opos_r;
  assign out_matches_res = omat_r;
  assign out_fill_count = 8'(cnt_r);
  assign out_empty_flag = cnt_r == '0;
  assign out_full_flag = full_now;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("fill above depth");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cnt_r))
    else $error("result lost");
endmodule
